FILE: rtl/utf8_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 code point decoder.
// Define NO_ASSERTIONS to compile them out.
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define U8CPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8cpd assertion failed");
// next-cycle implication
`define U8CPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8cpd assertion failed");
`else
`define U8CPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define U8CPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/u8cpd_pkg.sv
package u8cpd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CP_W       = 21;
    localparam int unsigned TAIL_W     = 6;
    localparam int unsigned TAIL_N     = 3;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned FIFO_DEPTH = 4;

    // group byte count: 0 = nothing pending, saturates at 4
    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THR  = 3'd3;
    localparam logic [CNT_W-1:0] CNT_MAX  = 3'd4;

    // lead byte classes
    localparam logic [BYTE_W-1:0] MASK_1B = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2B = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_3B = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_4B = 8'hF8;
    localparam logic [BYTE_W-1:0] MARK_1B = 8'h00;
    localparam logic [BYTE_W-1:0] MARK_2B = 8'hC0;
    localparam logic [BYTE_W-1:0] MARK_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] MARK_4B = 8'hF0;
    localparam logic [1:0]        CONT_TAG = 2'b10;

    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [TAIL_W-1:0] t_tail;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic last;
        t_cp  cp;
    } t_result;

    function automatic t_cp decode_group(
        input logic [BYTE_W-1:0] lead,
        input t_tail             t0,
        input t_tail             t1,
        input t_tail             t2,
        input t_cnt              cnt
    );
        t_cp cp;
        cp = '0;
        if (((lead & MASK_1B) == MARK_1B) && (cnt >= CNT_ONE)) begin
            cp = t_cp'(lead);
        end else if (((lead & MASK_2B) == MARK_2B) && (cnt >= CNT_TWO)) begin
            cp = t_cp'({lead[4:0], t0});
        end else if (((lead & MASK_3B) == MARK_3B) && (cnt >= CNT_THR)) begin
            cp = t_cp'({lead[3:0], t0, t1});
        end else if (((lead & MASK_4B) == MARK_4B) && (cnt >= CNT_MAX)) begin
            cp = {lead[2:0], t0, t1, t2};
        end
        return cp;
    endfunction

endpackage

FILE: rtl/utf8_codepoint_decoder.sv
// A code point is queued when the byte closing its group is accepted, then offered on m_axis.
// Throughput: one byte per cycle while output keeps up; a byte may yield two code points,
// which leave the queue (P_FIFO_DEPTH entries) one per cycle while m_axis_tready is high.
// s_axis_tready is high while the queue has room for two code points.
// Reset (i_rst_n, synchronous, active low) drops any pending group and empties the queue.
`include "utf8_codepoint_decoder_assert.svh"

module utf8_codepoint_decoder #(
    parameter int unsigned P_FIFO_DEPTH = u8cpd_pkg::FIFO_DEPTH  // >= 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [u8cpd_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // string_end
    // code point output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [u8cpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [20:0] code_point, [23:21] 0
    output logic                                m_axis_tlast    // last_of_string
);

    localparam int unsigned PTR_W = (P_FIFO_DEPTH > 1) ? $clog2(P_FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIM = CNT_W'(P_FIFO_DEPTH - 2);

    // ------------------------------------------------------------------
    // Group state. Tail entries only hold continuation payloads of the
    // current group, so they need no reset: decode never looks past the
    // count.
    // ------------------------------------------------------------------
    logic [u8cpd_pkg::BYTE_W-1:0] r_lead;
    u8cpd_pkg::t_tail             r_tail [u8cpd_pkg::TAIL_N];
    u8cpd_pkg::t_cnt              r_gcnt;

    logic [u8cpd_pkg::BYTE_W-1:0] n_lead;
    u8cpd_pkg::t_tail             n_tail [u8cpd_pkg::TAIL_N];
    u8cpd_pkg::t_cnt              n_gcnt;

    logic                         in_xfer;
    logic                         is_cont;
    logic                         append;     // byte extends the pending group
    logic                         tail_wr;    // append with a free tail slot
    logic [1:0]                   tail_idx;
    logic                         closed;     // pending group is closed by this byte
    u8cpd_pkg::t_cp               closed_cp;
    u8cpd_pkg::t_cp               end_cp;

    // ------------------------------------------------------------------
    // Output queue: small register ring, one read port at the head.
    // ------------------------------------------------------------------
    u8cpd_pkg::t_result           r_fifo [P_FIFO_DEPTH];
    logic [PTR_W-1:0]             r_wr_ptr;
    logic [PTR_W-1:0]             r_rd_ptr;
    logic [CNT_W-1:0]             r_qcnt;

    logic [PTR_W-1:0]             wr_ptr_p1;
    logic [PTR_W-1:0]             wr_ptr_p2;
    logic [PTR_W-1:0]             rd_ptr_p1;
    logic                         out_xfer;
    logic                         push_two;
    logic                         push_one;
    u8cpd_pkg::t_result           ent0;
    u8cpd_pkg::t_result           ent1;
    logic [CNT_W-1:0]             n_qcnt;
    u8cpd_pkg::t_result           head;

    assign s_axis_tready = (r_qcnt <= ROOM_LIM);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    // ------------------------------------------------------------------
    // Per-byte group update
    // ------------------------------------------------------------------
    assign is_cont  = (s_axis_tdata[7:6] == u8cpd_pkg::CONT_TAG);
    assign append   = is_cont && (r_gcnt != u8cpd_pkg::CNT_NONE);
    assign tail_wr  = append && (r_gcnt < u8cpd_pkg::CNT_MAX);
    assign tail_idx = 2'(r_gcnt - u8cpd_pkg::CNT_ONE);
    assign closed   = !append && (r_gcnt != u8cpd_pkg::CNT_NONE);

    always_comb begin
        if (append) begin
            n_lead = r_lead;
            n_gcnt = tail_wr ? (r_gcnt + u8cpd_pkg::CNT_ONE) : r_gcnt;
        end else begin
            // any other byte (a stray continuation too) opens a new group
            n_lead = s_axis_tdata;
            n_gcnt = u8cpd_pkg::CNT_ONE;
        end
        for (int i = 0; i < int'(u8cpd_pkg::TAIL_N); i++) begin
            n_tail[i] = (tail_wr && (tail_idx == 2'(i))) ? s_axis_tdata[5:0] : r_tail[i];
        end
    end

    // closed group decodes from the old state, string-end group from the new one
    assign closed_cp = u8cpd_pkg::decode_group(r_lead, r_tail[0], r_tail[1], r_tail[2],
                                               r_gcnt);
    assign end_cp    = u8cpd_pkg::decode_group(n_lead, n_tail[0], n_tail[1], n_tail[2],
                                               n_gcnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_gcnt <= u8cpd_pkg::CNT_NONE;
        end else if (in_xfer) begin
            r_lead <= n_lead;
            r_gcnt <= s_axis_tlast ? u8cpd_pkg::CNT_NONE : n_gcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && tail_wr) begin
            r_tail[tail_idx] <= s_axis_tdata[5:0];
        end
    end

    // ------------------------------------------------------------------
    // Queue write: closed group first (tlast 0), then string-end group.
    // ------------------------------------------------------------------
    assign push_two = in_xfer && closed && s_axis_tlast;
    assign push_one = in_xfer && (closed != s_axis_tlast);

    always_comb begin
        ent1.cp   = end_cp;
        ent1.last = 1'b1;
        if (closed) begin
            ent0.cp   = closed_cp;
            ent0.last = 1'b0;
        end else begin
            ent0 = ent1;
        end
    end

    assign wr_ptr_p1 = (r_wr_ptr == PTR_LAST) ? '0 : (r_wr_ptr + 1'b1);
    assign wr_ptr_p2 = (wr_ptr_p1 == PTR_LAST) ? '0 : (wr_ptr_p1 + 1'b1);
    assign rd_ptr_p1 = (r_rd_ptr == PTR_LAST) ? '0 : (r_rd_ptr + 1'b1);

    always_comb begin
        n_qcnt = r_qcnt;
        if (push_two) begin
            n_qcnt = n_qcnt + CNT_W'(2);
        end else if (push_one) begin
            n_qcnt = n_qcnt + CNT_W'(1);
        end
        if (out_xfer) begin
            n_qcnt = n_qcnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            r_qcnt <= n_qcnt;
            if (push_two) begin
                r_wr_ptr <= wr_ptr_p2;
            end else if (push_one) begin
                r_wr_ptr <= wr_ptr_p1;
            end
            if (out_xfer) begin
                r_rd_ptr <= rd_ptr_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_two || push_one) begin
            r_fifo[r_wr_ptr] <= ent0;
        end
        if (push_two) begin
            r_fifo[wr_ptr_p1] <= ent1;
        end
    end

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_qcnt != '0);
    assign m_axis_tdata  = u8cpd_pkg::OUT_DATA_W'(head.cp);
    assign m_axis_tlast  = head.last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `U8CPD_ASSERT_IMP(a_gcnt_range, i_clk, i_rst_n, 1'b1, r_gcnt <= u8cpd_pkg::CNT_MAX)
    `U8CPD_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, in_xfer && s_axis_tlast,
                      r_gcnt == u8cpd_pkg::CNT_NONE)
    `U8CPD_ASSERT_NXT(a_lead_opens, i_clk, i_rst_n, in_xfer && !s_axis_tlast && !is_cont,
                      r_gcnt == u8cpd_pkg::CNT_ONE)
    `U8CPD_ASSERT_NXT(a_end_pushes, i_clk, i_rst_n, in_xfer && s_axis_tlast && !out_xfer,
                      r_qcnt > $past(r_qcnt))

endmodule
